>>> design/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared constants and types for the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // full scale of saturation and value channels
  localparam logic [7:0]  FULL_SCALE  = 8'd255;

  // 255 * 65536, denominator of the q and t levels
  localparam logic [23:0] LEVEL_DEN   = 24'hFF0000;

  // reciprocal of 255 for 16-bit numerators: x / 255 == (x * 0x8081) >> 23
  localparam logic [15:0] RECIP_255   = 16'h8081;
  localparam int          RECIP_SHIFT = 23;

  // hue sectors of the six-case table
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

>>> design/hsv2rgb_div255.sv
// ----------------------------------------------------------------------------
// hsv2rgb_div255
// truncating divide of a 16-bit value by 255 through a reciprocal multiply
// ----------------------------------------------------------------------------
module hsv2rgb_div255 (
  input  logic [15:0] num,
  output logic [7:0]  quo
);
  import hsv2rgb_pkg::*;

  logic [31:0] prod;

  assign prod = 32'(num) * 32'(RECIP_255);
  // exact for every 16-bit numerator, result fits 8 bits for num <= 65279
  assign quo  = prod[RECIP_SHIFT +: 8];

endmodule

>>> design/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// five-stage pipeline turning one hue/saturation/value item into red/green/blue
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the output accepts, set by the one-multiply-deep stage split
// each stage holds its item while the next stage is full and stalled
// bubbles in the pipe are filled even while the output waits
// reset (rst_n low, synchronous) clears all stage valid bits, payload is not reset
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);
  import hsv2rgb_pkg::*;

  // per-stage valid bits and ready chain
  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5      = !vld5_r || out_tready;
  assign rdy4      = !vld4_r || rdy5;
  assign rdy3      = !vld3_r || rdy4;
  assign rdy2      = !vld2_r || rdy3;
  assign rdy1      = !vld1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      if (rdy1) vld1_r <= in_tvalid;
      if (rdy2) vld2_r <= vld1_r;
      if (rdy3) vld3_r <= vld2_r;
      if (rdy4) vld4_r <= vld3_r;
      if (rdy5) vld5_r <= vld4_r;
    end
  end

  // ---- stage 1: hue * 6, split into sector and fraction
  logic [15:0] in_hue;
  logic [7:0]  in_sat;
  logic [7:0]  in_bri;
  logic [18:0] h6_nxt;
  logic [2:0]  sec1_r;
  logic [15:0] f1_r;
  logic [7:0]  s1_r;
  logic [7:0]  b1_r;

  assign in_hue = in_tdata[15:0];
  assign in_sat = in_tdata[23:16];
  assign in_bri = in_tdata[31:24];
  // hue*6 as hue*4 + hue*2
  assign h6_nxt = {1'b0, in_hue, 2'b00} + {2'b00, in_hue, 1'b0};

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sec1_r <= h6_nxt[18:16];
      f1_r   <= h6_nxt[15:0];
      s1_r   <= in_sat;
      b1_r   <= in_bri;
    end
  end

  // ---- stage 2: f*s and the level multipliers for q, t and p
  logic [7:0]  inv_s;
  logic [23:0] fs;
  logic [23:0] mq_nxt;
  logic [23:0] mt_nxt;
  logic [15:0] pv_nxt;
  logic [2:0]  sec2_r;
  logic [7:0]  b2_r;
  logic [23:0] mq2_r;
  logic [23:0] mt2_r;
  logic [15:0] pv2_r;

  assign inv_s  = FULL_SCALE - s1_r;
  assign fs     = 24'(f1_r) * 24'(s1_r);
  // q term: 255*65536 - f*s
  assign mq_nxt = LEVEL_DEN - fs;
  // t term: 255*65536 - (65536-f)*s, rewritten as (255-s)*65536 + f*s
  assign mt_nxt = {inv_s, 16'h0000} + fs;
  assign pv_nxt = 16'(b1_r) * 16'(inv_s);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sec2_r <= sec1_r;
      b2_r   <= b1_r;
      mq2_r  <= mq_nxt;
      mt2_r  <= mt_nxt;
      pv2_r  <= pv_nxt;
    end
  end

  // ---- stage 3: scale by value, drop the 16 fraction bits
  logic [31:0] nq_nxt;
  logic [31:0] nt_nxt;
  logic [2:0]  sec3_r;
  logic [7:0]  b3_r;
  logic [15:0] xq3_r;
  logic [15:0] xt3_r;
  logic [15:0] xp3_r;

  assign nq_nxt = 32'(b2_r) * 32'(mq2_r);
  assign nt_nxt = 32'(b2_r) * 32'(mt2_r);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      sec3_r <= sec2_r;
      b3_r   <= b2_r;
      // floor(n / (255*65536)) == floor(floor(n / 65536) / 255)
      xq3_r  <= nq_nxt[31:16];
      xt3_r  <= nt_nxt[31:16];
      xp3_r  <= pv2_r;
    end
  end

  // ---- stage 4: divide by 255
  logic [7:0] p_nxt;
  logic [7:0] q_nxt;
  logic [7:0] t_nxt;
  logic [2:0] sec4_r;
  logic [7:0] v4_r;
  logic [7:0] p4_r;
  logic [7:0] q4_r;
  logic [7:0] t4_r;

  hsv2rgb_div255 u_div_p (.num(xp3_r), .quo(p_nxt));
  hsv2rgb_div255 u_div_q (.num(xq3_r), .quo(q_nxt));
  hsv2rgb_div255 u_div_t (.num(xt3_r), .quo(t_nxt));

  always_ff @(posedge clk) begin
    if (rdy4) begin
      sec4_r <= sec3_r;
      v4_r   <= b3_r;
      p4_r   <= p_nxt;
      q4_r   <= q_nxt;
      t4_r   <= t_nxt;
    end
  end

  // ---- stage 5: place levels into channels by sector
  logic [23:0] rgb_nxt;
  logic [23:0] out_tdata_r;

  always_comb begin
    case (sector_t'(sec4_r))
      SEC_RED_YEL: rgb_nxt = {p4_r, t4_r, v4_r};
      SEC_YEL_GRN: rgb_nxt = {p4_r, v4_r, q4_r};
      SEC_GRN_CYN: rgb_nxt = {t4_r, v4_r, p4_r};
      SEC_CYN_BLU: rgb_nxt = {v4_r, q4_r, p4_r};
      SEC_BLU_MAG: rgb_nxt = {v4_r, p4_r, t4_r};
      SEC_MAG_RED: rgb_nxt = {q4_r, p4_r, v4_r};
      default:     rgb_nxt = 24'h000000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_tdata_r <= rgb_nxt;
    end
  end

  assign out_tvalid = vld5_r;
  assign out_tdata  = out_tdata_r;

  // ---- assertions
  // every derived level stays at or below the value
  a_levels_le_value: assert property (@(posedge clk) disable iff (!rst_n)
    vld4_r |-> (p4_r <= v4_r) && (q4_r <= v4_r) && (t4_r <= v4_r))
    else $error("derived level exceeds value");

  // a stalled item in stage 3 keeps its data and its valid bit
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld3_r && !rdy4 |=> vld3_r && $stable(xq3_r) && $stable(xt3_r) && $stable(sec3_r))
    else $error("stage 3 item lost under stall");

  // the input is refused only when the whole pipe is full and the output stalls
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> vld1_r && vld2_r && vld3_r && vld4_r && vld5_r && !out_tready)
    else $error("input refused with a free stage");

  // reset empties the pipe
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !vld1_r)
    else $error("pipe not empty after reset");

endmodule

>>> dv/hsv_to_rgb_converter_tb.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// streams hue/saturation/value items through the converter and compares each
// red/green/blue result with an in-bench integer model of the six-sector
// conversion, under varying input gaps, output stalls and a long output hold
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          SHOW_LIMIT  = 10;
  localparam logic [63:0] LVL_DEN     = 64'd255 * 64'd65536;

  // input item, hue in the lowest bits
  typedef struct packed {
    logic [7:0]  brightness;
    logic [7:0]  saturation;
    logic [15:0] hue;
  } hsv_t;

  // result item, red in the lowest bits
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct {
    hsv_t src;
    rgb_t rgb;
  } pending_rgb_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  pending_rgb_t rgb_expected_q[$];

  int idle_pct       = 0;
  int stall_pct      = 0;
  int hold_len       = 0;
  int hold_req       = 0;
  int hold_ack       = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int colors_sent    = 0;
  int rgb_checked    = 0;
  int mismatch_count = 0;
  int grey_count     = 0;
  int in_stall_count = 0;
  int sector_hits[6];

  hsv_to_rgb_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // integer model: sector from the top bits of hue*6, fraction from the low 16
  function automatic rgb_t hsv_to_rgb_expected(hsv_t c);
    logic [18:0] hue_x6;
    logic [63:0] v, s, frac, lvl_p, lvl_q, lvl_t;
    sector_t     sec;
    rgb_t        rgb;
    hue_x6 = {3'b000, c.hue} * 19'd6;
    sec    = sector_t'(hue_x6[18:16]);
    frac   = 64'(hue_x6[15:0]);
    v      = 64'(c.brightness);
    s      = 64'(c.saturation);
    lvl_p  = (v * (64'd255 - s)) / 64'd255;
    lvl_q  = (v * (LVL_DEN - frac * s)) / LVL_DEN;
    lvl_t  = (v * (LVL_DEN - (64'd65536 - frac) * s)) / LVL_DEN;
    case (sec)
      SEC_RED_YEL: rgb = '{blue: lvl_p[7:0], green: lvl_t[7:0], red: v[7:0]};
      SEC_YEL_GRN: rgb = '{blue: lvl_p[7:0], green: v[7:0],     red: lvl_q[7:0]};
      SEC_GRN_CYN: rgb = '{blue: lvl_t[7:0], green: v[7:0],     red: lvl_p[7:0]};
      SEC_CYN_BLU: rgb = '{blue: v[7:0],     green: lvl_q[7:0], red: lvl_p[7:0]};
      SEC_BLU_MAG: rgb = '{blue: v[7:0],     green: lvl_p[7:0], red: lvl_t[7:0]};
      SEC_MAG_RED: rgb = '{blue: lvl_q[7:0], green: lvl_p[7:0], red: v[7:0]};
      default:     rgb = '0;
    endcase
    return rgb;
  endfunction

  // sector index of a hue, for the coverage summary
  function automatic int hue_sector(logic [15:0] hue);
    logic [18:0] hue_x6;
    hue_x6 = {3'b000, hue} * 19'd6;
    return int'(hue_x6[18:16]);
  endfunction

  // mostly uniform colors, with a share near the field extremes and sector edges
  function automatic hsv_t random_color();
    int   edge_hue[7] = '{0, 10923, 21846, 32768, 43691, 54614, 65536};
    hsv_t c;
    c.hue        = 16'($urandom);
    c.saturation = 8'($urandom);
    c.brightness = 8'($urandom);
    case ($urandom_range(9))
      0: c.saturation = $urandom_range(1) ? 8'hFF : 8'h00;
      1: c.brightness = $urandom_range(1) ? 8'hFF : 8'h00;
      2: c.hue = 16'(edge_hue[$urandom_range(6)] + $urandom_range(4) - 2);
      default: ;
    endcase
    return c;
  endfunction

  // reset held low from time zero, released once
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, rgb_expected_q.size());
      $display("hsv_to_rgb_converter_tb failed");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold when a test asks for one
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // every accepted item gets its prediction queued
  always @(posedge clk) begin
    pending_rgb_t pred_item;
    if (rst_n && in_tvalid && in_tready) begin
      pred_item.src  = hsv_t'(in_tdata);
      pred_item.rgb  = hsv_to_rgb_expected(hsv_t'(in_tdata));
      rgb_expected_q = {rgb_expected_q, pred_item};
      colors_sent++;
      sector_hits[hue_sector(in_tdata[15:0])]++;
      if (in_tdata[23:16] == 8'h00) grey_count++;
    end
    if (rst_n && in_tvalid && !in_tready) in_stall_count++;
  end

  // every accepted result is compared with the oldest prediction
  always @(posedge clk) begin
    pending_rgb_t exp_item;
    rgb_t         got;
    if (rst_n && out_tvalid && out_tready) begin
      got = rgb_t'(out_tdata);
      if (rgb_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("unexpected result r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
      end else begin
        exp_item = rgb_expected_q.pop_front();
        rgb_checked++;
        if (got.red !== exp_item.rgb.red || got.green !== exp_item.rgb.green ||
            got.blue !== exp_item.rgb.blue) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("mismatch h=%0d s=%0d v=%0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     exp_item.src.hue, exp_item.src.saturation, exp_item.src.brightness,
                     exp_item.rgb.red, exp_item.rgb.green, exp_item.rgb.blue,
                     got.red, got.green, got.blue);
        end
      end
    end
  end

  // offer one item, with random idle cycles first, and wait for its handshake
  task automatic send_color(input hsv_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rgb_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_colors(input int n);
    repeat (n) send_color(random_color());
  endtask

  // field extremes, every sector and its edges, grey
  task automatic test_corner_colors();
    hsv_t corners[$];
    idle_pct  = 0;
    stall_pct = 0;
    corners = '{
      '{hue: 16'd0,     saturation: 8'd0,   brightness: 8'd0},
      '{hue: 16'd65535, saturation: 8'd255, brightness: 8'd255},
      '{hue: 16'd0,     saturation: 8'd255, brightness: 8'd255},
      '{hue: 16'd10922, saturation: 8'd255, brightness: 8'd255},
      '{hue: 16'd10923, saturation: 8'd255, brightness: 8'd255},
      '{hue: 16'd21845, saturation: 8'd255, brightness: 8'd200},
      '{hue: 16'd21846, saturation: 8'd255, brightness: 8'd200},
      '{hue: 16'd32767, saturation: 8'd128, brightness: 8'd255},
      '{hue: 16'd32768, saturation: 8'd128, brightness: 8'd255},
      '{hue: 16'd43690, saturation: 8'd255, brightness: 8'd255},
      '{hue: 16'd43691, saturation: 8'd255, brightness: 8'd255},
      '{hue: 16'd54613, saturation: 8'd1,   brightness: 8'd255},
      '{hue: 16'd54614, saturation: 8'd254, brightness: 8'd255},
      '{hue: 16'd5461,  saturation: 8'd0,   brightness: 8'd137},  // grey
      '{hue: 16'd49151, saturation: 8'd0,   brightness: 8'd255},  // grey, full level
      '{hue: 16'd27306, saturation: 8'd255, brightness: 8'd0},
      '{hue: 16'd65535, saturation: 8'd0,   brightness: 8'd1},
      '{hue: 16'd16384, saturation: 8'd170, brightness: 8'd85},
      '{hue: 16'd60000, saturation: 8'd255, brightness: 8'd1}
    };
    foreach (corners[i]) send_color(corners[i]);
    wait_for_results();
  endtask

  task automatic test_back_to_back();
    idle_pct  = 0;
    stall_pct = 0;
    send_random_colors(400);
  endtask

  task automatic test_sender_gaps();
    idle_pct  = 66;
    stall_pct = 0;
    send_random_colors(350);
  endtask

  task automatic test_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 66;
    send_random_colors(350);
  endtask

  task automatic test_both_sides_idle();
    idle_pct  = 16;
    stall_pct = 16;
    send_random_colors(350);
  endtask

  // long output hold while items keep coming: the pipe fills and stalls its input
  task automatic test_output_holdoff();
    idle_pct  = 0;
    stall_pct = 0;
    hold_len  = 200;
    hold_req++;
    send_random_colors(150);
  endtask

  // pause the sender until the pipe is empty, then resume
  task automatic test_drain_pause();
    idle_pct  = 0;
    stall_pct = 30;
    send_random_colors(60);
    wait_for_results();
    send_random_colors(60);
  endtask

  initial begin
    int leftover;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    test_corner_colors();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    test_output_holdoff();
    test_drain_pause();

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    leftover = rgb_expected_q.size();

    $display("colors sent %0d, results checked %0d, grey inputs %0d, input stall cycles %0d",
             colors_sent, rgb_checked, grey_count, in_stall_count);
    $display("sector hits %0d %0d %0d %0d %0d %0d, mismatches %0d, leftover %0d",
             sector_hits[0], sector_hits[1], sector_hits[2], sector_hits[3],
             sector_hits[4], sector_hits[5], mismatch_count, leftover);
    if (mismatch_count == 0 && leftover == 0) begin
      $display("hsv_to_rgb_converter_tb passed");
    end else begin
      $display("hsv_to_rgb_converter_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/hsv2rgb_pkg.sv
design/hsv2rgb_div255.sv
design/hsv_to_rgb_converter.sv
dv/hsv_to_rgb_converter_tb.sv
